// File: hdl/sliding_window_latency_percentiles_top_assert.svh
// assertion macros for the sliding-window latency percentile block
// used by sliding_window_latency_percentiles_top; needs nothing else
`ifndef SLIDING_WINDOW_LATENCY_PERCENTILES_TOP_ASSERT_SVH
`define SLIDING_WINDOW_LATENCY_PERCENTILES_TOP_ASSERT_SVH

// same-cycle implication
`define SWLP_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWLP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/swlp_pkg.sv
// shared types and constants of the sliding-window latency percentile block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package swlp_pkg;

    localparam int WINDOW_DEF  = 1000;
    localparam int MIN_SAMPLES = 100;
    localparam int SAMPLE_W    = 16;
    localparam int BIT_IDX_W   = 4;
    localparam int N_THR       = 5;
    localparam int PASS_W      = 5;
    localparam int FINAL_PASS  = 16;
    localparam int SCALE_W     = 7;
    localparam int IDX_W       = 3;
    localparam int LAST_RES    = 4;

    typedef enum logic {
        MODE_RECORD = 1'b0,
        MODE_QUERY  = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // scale factor of each mean-style result
    function automatic logic [SCALE_W-1:0] scale_f(input logic [IDX_W-1:0] j);
        logic [SCALE_W-1:0] s;
        begin
            case (j)
                3'd0:    s = 7'd100;
                3'd1:    s = 7'd20;
                3'd2:    s = 7'd10;
                3'd3:    s = 7'd2;
                default: s = 7'd1;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/swlp_req_if.sv
// request channel: record or query transaction
// depends on swlp_pkg
`timescale 1ns / 1ps
`default_nettype none
interface swlp_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [swlp_pkg::SAMPLE_W-1:0] sample_ms;

    modport source (output valid, output mode, output sample_ms, input ready);
    modport sink   (input valid, input mode, input sample_ms, output ready);
endinterface
`default_nettype wire

// File: hdl/swlp_rsp_if.sv
// result channel: percentile statistics transaction
// depends on swlp_pkg
`timescale 1ns / 1ps
`default_nettype none
interface swlp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [swlp_pkg::SAMPLE_W-1:0] top1_mean;
    logic [swlp_pkg::SAMPLE_W-1:0] top5_mean;
    logic [swlp_pkg::SAMPLE_W-1:0] top10_mean;
    logic [swlp_pkg::SAMPLE_W-1:0] top50_mean;
    logic [swlp_pkg::SAMPLE_W-1:0] median_ms;
    logic [swlp_pkg::SAMPLE_W-1:0] overall_mean;

    modport source (output valid, output top1_mean, output top5_mean, output top10_mean,
                    output top50_mean, output median_ms, output overall_mean, input ready);
    modport sink   (input valid, input top1_mean, input top5_mean, input top10_mean,
                    input top50_mean, input median_ms, input overall_mean, output ready);
endinterface
`default_nettype wire

// File: hdl/swlp_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module swlp_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1000
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [DATA_W-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [DATA_W-1:0]          rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: hdl/swlp_div.sv
// restoring divider, one quotient bit per cycle
// depends on swlp_pkg
`timescale 1ns / 1ps
`default_nettype none
module swlp_div #(
    parameter int DVD_W = 36,
    parameter int DSR_W = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DVD_W-1:0]   dividend,
    input  wire logic [DSR_W-1:0]   divisor,
    output logic      [DVD_W-1:0]   quotient,
    output swlp_pkg::div_stat_t     stat
);
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg;
    logic [DSR_W:0]    rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DSR_W:0]    shifted;
    logic              fits;

    // trial subtraction
    always_comb
    begin
        shifted = {rem_reg[DSR_W-1:0], quo_reg[DVD_W-1]};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? (shifted - {1'b0, dsr_reg}) : shifted;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule
`default_nettype wire

// File: hdl/sliding_window_latency_percentiles_top.sv
// Sliding-window latency percentiles.
// req channel: mode 0 records sample_ms into a circular store of WINDOW entries
//   (oldest dropped when full) and gives no result; mode 1 asks for statistics.
// rsp channel: one transaction per query with top1/5/10/50 means, median and
//   overall mean of the held samples; all zero while fewer than 100 are held.
// A record writes the sample into the memory at the write position. For a query
//   the ranking is a bit-by-bit threshold search, sixteen read passes plus a
//   summing pass over the sample memory at one read a cycle, then five divisions
//   on one shared serial divider, one quotient bit a cycle.
// req.ready is low while a query is worked on; records are taken while an
//   earlier result still waits on rsp.
// A stalled rsp holds its result; a further finished query waits in the block.
// Reset empties the window (count and write position to zero); the memory
//   itself is not cleared, as only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_latency_percentiles_top_assert.svh"
module sliding_window_latency_percentiles_top #(
    parameter int WINDOW = swlp_pkg::WINDOW_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    swlp_req_if.sink   req,
    swlp_rsp_if.source rsp
);
    localparam int SW     = swlp_pkg::SAMPLE_W;
    localparam int ADDR_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SW + CNT_W;
    localparam int DVD_W  = SUM_W + swlp_pkg::SCALE_W;
    localparam int NT     = swlp_pkg::N_THR;
    localparam int IW     = swlp_pkg::IDX_W;

    swlp_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] wpos_reg;
    logic [CNT_W-1:0]  k100_reg, k20_reg, k10_reg;
    logic [6:0]        r100_reg;
    logic [4:0]        r20_reg;
    logic [3:0]        r10_reg;

    logic [swlp_pkg::PASS_W-1:0] pass_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              issue_reg, vld_reg;
    logic [SW-1:0]     thr_reg [NT];
    logic [CNT_W-1:0]  cnt_reg [NT];
    logic [SUM_W-1:0]  sum_reg [NT-1];
    logic [SUM_W-1:0]  tot_reg;
    logic [IW-1:0]     j_reg;
    logic [SUM_W-1:0]  prod_reg;
    logic [SW-1:0]     q_reg [NT];
    logic              zero_reg;

    logic              out_vld_reg;
    logic [SW-1:0]     o_top1_reg, o_top5_reg, o_top10_reg, o_top50_reg;
    logic [SW-1:0]     o_med_reg, o_mean_reg;

    logic [CNT_W-1:0]  kk [NT];
    logic [SW-1:0]     cand [NT];
    logic [SW-1:0]     rdata;
    logic              rec_acc, qry_acc, scan_end, final_pass, out_free;
    logic              div_start;
    logic [DVD_W-1:0]  dividend, quotient;
    swlp_pkg::div_stat_t div_stat;

    // sample memory
    swlp_ram #(
        .DATA_W (SW),
        .DEPTH  (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (rec_acc),
        .waddr (wpos_reg),
        .wdata (req.sample_ms),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // shared divider
    swlp_div #(
        .DVD_W (DVD_W),
        .DSR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // ranks searched and trial thresholds
    always_comb
    begin
        kk[0] = k100_reg;
        kk[1] = k20_reg;
        kk[2] = k10_reg;
        kk[3] = count_reg >> 1;
        kk[4] = (count_reg >> 1) + 1'b1;
        for (int i = 0; i < NT; i++)
        begin
            cand[i] = thr_reg[i] | (SW'(1) << (SW - 1 - int'(pass_reg[swlp_pkg::BIT_IDX_W-1:0])));
        end
    end

    // handshake decode and outputs
    always_comb
    begin
        req.ready  = (state_reg == swlp_pkg::S_IDLE);
        rec_acc    = req.valid && req.ready && (req.mode == swlp_pkg::MODE_RECORD);
        qry_acc    = req.valid && req.ready && (req.mode == swlp_pkg::MODE_QUERY);
        scan_end   = (state_reg == swlp_pkg::S_SCAN) && !issue_reg && !vld_reg;
        final_pass = (pass_reg == swlp_pkg::PASS_W'(swlp_pkg::FINAL_PASS));
        out_free   = !out_vld_reg || rsp.ready;
        div_start  = (state_reg == swlp_pkg::S_LOAD);
        if (j_reg == IW'(swlp_pkg::LAST_RES))
        begin
            dividend = DVD_W'(tot_reg);
        end
        else
        begin
            dividend = DVD_W'(swlp_pkg::scale_f(j_reg))
                     * (DVD_W'(sum_reg[j_reg[1:0]]) + DVD_W'(prod_reg));
        end
        rsp.valid        = out_vld_reg;
        rsp.top1_mean    = o_top1_reg;
        rsp.top5_mean    = o_top5_reg;
        rsp.top10_mean   = o_top10_reg;
        rsp.top50_mean   = o_top50_reg;
        rsp.median_ms    = o_med_reg;
        rsp.overall_mean = o_mean_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swlp_pkg::S_IDLE:
            begin
                if (qry_acc)
                begin
                    state_next = (count_reg < CNT_W'(swlp_pkg::MIN_SAMPLES))
                               ? swlp_pkg::S_OUT : swlp_pkg::S_SCAN;
                end
            end
            swlp_pkg::S_SCAN:
            begin
                if (scan_end && final_pass)
                begin
                    state_next = swlp_pkg::S_MUL;
                end
            end
            swlp_pkg::S_MUL:  state_next = swlp_pkg::S_LOAD;
            swlp_pkg::S_LOAD: state_next = swlp_pkg::S_DIV;
            swlp_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = (j_reg == IW'(swlp_pkg::LAST_RES))
                               ? swlp_pkg::S_OUT : swlp_pkg::S_MUL;
                end
            end
            swlp_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = swlp_pkg::S_IDLE;
                end
            end
            default: state_next = swlp_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= swlp_pkg::S_IDLE;
            count_reg   <= '0;
            wpos_reg    <= '0;
            k100_reg    <= '0;
            k20_reg     <= '0;
            k10_reg     <= '0;
            r100_reg    <= '0;
            r20_reg     <= '0;
            r10_reg     <= '0;
            pass_reg    <= '0;
            addr_reg    <= '0;
            issue_reg   <= 1'b0;
            vld_reg     <= 1'b0;
            j_reg       <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // window bookkeeping on a record
            if (rec_acc)
            begin
                wpos_reg <= (wpos_reg == ADDR_W'(WINDOW - 1)) ? '0 : wpos_reg + 1'b1;
                if (count_reg < CNT_W'(WINDOW))
                begin
                    count_reg <= count_reg + 1'b1;
                    if (r100_reg == 7'd99)
                    begin
                        r100_reg <= '0;
                        k100_reg <= k100_reg + 1'b1;
                    end
                    else
                    begin
                        r100_reg <= r100_reg + 1'b1;
                    end
                    if (r20_reg == 5'd19)
                    begin
                        r20_reg <= '0;
                        k20_reg <= k20_reg + 1'b1;
                    end
                    else
                    begin
                        r20_reg <= r20_reg + 1'b1;
                    end
                    if (r10_reg == 4'd9)
                    begin
                        r10_reg <= '0;
                        k10_reg <= k10_reg + 1'b1;
                    end
                    else
                    begin
                        r10_reg <= r10_reg + 1'b1;
                    end
                end
            end

            // read sequencing over the held samples
            vld_reg <= issue_reg;
            if (issue_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(count_reg - 1'b1))
                begin
                    issue_reg <= 1'b0;
                end
            end
            if ((qry_acc && state_next == swlp_pkg::S_SCAN) || (scan_end && !final_pass))
            begin
                issue_reg <= 1'b1;
                addr_reg  <= '0;
            end
            if (qry_acc)
            begin
                pass_reg <= '0;
            end
            else if (scan_end && !final_pass)
            begin
                pass_reg <= pass_reg + 1'b1;
            end

            // result index
            if (scan_end && final_pass)
            begin
                j_reg <= '0;
            end
            else if (state_reg == swlp_pkg::S_DIV && div_stat.done
                     && j_reg != IW'(swlp_pkg::LAST_RES))
            begin
                j_reg <= j_reg + 1'b1;
            end

            // output register
            if (state_reg == swlp_pkg::S_OUT && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ranking and result datapath
    always_ff @(posedge clk)
    begin
        if (qry_acc)
        begin
            zero_reg <= (count_reg < CNT_W'(swlp_pkg::MIN_SAMPLES));
            tot_reg  <= '0;
            for (int i = 0; i < NT; i++)
            begin
                thr_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            for (int i = 0; i < NT - 1; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (scan_end && !final_pass)
        begin
            // keep the trial bit where enough samples reach it
            for (int i = 0; i < NT; i++)
            begin
                if (cnt_reg[i] >= kk[i])
                begin
                    thr_reg[i] <= cand[i];
                end
                cnt_reg[i] <= '0;
            end
        end
        else if (vld_reg)
        begin
            if (final_pass)
            begin
                tot_reg <= tot_reg + SUM_W'(rdata);
                for (int i = 0; i < NT - 1; i++)
                begin
                    if (rdata > thr_reg[i])
                    begin
                        cnt_reg[i] <= cnt_reg[i] + 1'b1;
                        sum_reg[i] <= sum_reg[i] + SUM_W'(rdata);
                    end
                end
            end
            else
            begin
                for (int i = 0; i < NT; i++)
                begin
                    if (rdata >= cand[i])
                    begin
                        cnt_reg[i] <= cnt_reg[i] + 1'b1;
                    end
                end
            end
        end

        // samples tied at the threshold that still belong to the top group
        if (state_reg == swlp_pkg::S_MUL && j_reg != IW'(swlp_pkg::LAST_RES))
        begin
            prod_reg <= SUM_W'(kk[j_reg] - cnt_reg[j_reg]) * SUM_W'(thr_reg[j_reg]);
        end

        if (state_reg == swlp_pkg::S_DIV && div_stat.done)
        begin
            q_reg[j_reg] <= quotient[SW-1:0];
        end

        if (state_reg == swlp_pkg::S_OUT && out_free)
        begin
            o_top1_reg  <= zero_reg ? '0 : q_reg[0];
            o_top5_reg  <= zero_reg ? '0 : q_reg[1];
            o_top10_reg <= zero_reg ? '0 : q_reg[2];
            o_top50_reg <= zero_reg ? '0 : q_reg[3];
            o_med_reg   <= zero_reg ? '0 : thr_reg[4];
            o_mean_reg  <= zero_reg ? '0 : q_reg[4];
        end
    end

    // checks
    `SWLP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(WINDOW), "count overflow")
    `SWLP_ASSERT_NEXT(a_query_scan, clk, rst_n, qry_acc && count_reg >= CNT_W'(swlp_pkg::MIN_SAMPLES), state_reg == swlp_pkg::S_SCAN && pass_reg == '0, "query did not start scan")
    `SWLP_ASSERT_NOW(a_pass_bound, clk, rst_n, state_reg == swlp_pkg::S_SCAN, pass_reg <= swlp_pkg::PASS_W'(swlp_pkg::FINAL_PASS), "pass overrun")
    `SWLP_ASSERT_NEXT(a_count_step, clk, rst_n, rec_acc && count_reg < CNT_W'(WINDOW), count_reg == $past(count_reg) + 1'b1, "count not advanced")

endmodule
`default_nettype wire

// File: tb/sv/sliding_window_latency_percentiles_top_tb.sv
`timescale 1ns / 1ps
// testbench for the sliding-window latency percentile block: record/query transactions
// against an in-bench window predictor, random idling and a long result stall
// depends on swlp_pkg, swlp_req_if, swlp_rsp_if and sliding_window_latency_percentiles_top
module sliding_window_latency_percentiles_top_tb;
    import swlp_pkg::*;

    localparam int WIN        = WINDOW_DEF;
    localparam int HOLD_TICKS = 8000;
    localparam int ITEM_GOAL  = 1450;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t top1;
        sample_t top5;
        sample_t top10;
        sample_t top50;
        sample_t median;
        sample_t mean;
    } stats_t;

    logic clk;
    logic rst_n;

    swlp_req_if req ();
    swlp_rsp_if rsp ();

    sliding_window_latency_percentiles_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // window copy held by the predictor
    sample_t window_mem [WIN];
    int      held_count;
    int      write_slot;

    stats_t  pending_stats [$];
    int      mismatches;
    int      checked_results;
    int      records_sent;
    int      queries_sent;
    bit      no_idle;
    bit      hold_rsp;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // statistics over the held samples, ranked largest first
    function automatic stats_t rank_stats();
        int          ranked [$];
        longint      s1, s5, s10, s50, total;
        stats_t      r;
        int          n;
        n = held_count;
        s1 = 0;
        s5 = 0;
        s10 = 0;
        s50 = 0;
        total = 0;
        r = '0;
        if (n < MIN_SAMPLES)
        begin
            return r;
        end
        for (int i = 0; i < n; i++)
        begin
            ranked.push_back(int'(window_mem[i]));
        end
        ranked.rsort();
        for (int i = 0; i < n; i++)
        begin
            if (i < n / 100) s1 += ranked[i];
            if (i < n / 20) s5 += ranked[i];
            if (i < n / 10) s10 += ranked[i];
            if (i < n / 2) s50 += ranked[i];
            total += ranked[i];
        end
        r.top1   = sample_t'((100 * s1) / n);
        r.top5   = sample_t'((20 * s5) / n);
        r.top10  = sample_t'((10 * s10) / n);
        r.top50  = sample_t'((2 * s50) / n);
        r.median = sample_t'(ranked[n / 2]);
        r.mean   = sample_t'(total / n);
        return r;
    endfunction

    // window update or expected result for one accepted transaction
    task automatic apply_item(input mode_t m, input sample_t s);
        if (m == MODE_RECORD)
        begin
            window_mem[write_slot] = s;
            write_slot = (write_slot + 1 >= WIN) ? 0 : write_slot + 1;
            if (held_count < WIN) held_count++;
            records_sent++;
        end
        else
        begin
            pending_stats.push_back(rank_stats());
            queries_sent++;
        end
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (no_idle || p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // offer one transaction and wait for acceptance
    task automatic send_item(input mode_t m, input sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.mode      <= m;
        req.sample_ms <= s;
        do
            @(posedge clk);
        while (!req.ready);
        apply_item(m, s);
    endtask

    function automatic sample_t pick_sample();
        int p;
        p = $urandom_range(99);
        if (p < 55) return sample_t'($urandom_range(300));
        if (p < 75) return sample_t'($urandom);
        if (p < 85) return '1;
        if (p < 92) return '0;
        return sample_t'($urandom_range(65535, 60000));
    endfunction

    // stop offering and wait until every expected result has arrived
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // result side: random stalls, or one long hold-off when asked
    initial
    begin
        int len;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_TICKS) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (!no_idle && $urandom_range(9) == 0)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3, 1);
                rsp.ready <= 1'b0;
                repeat (len) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        stats_t got;
        stats_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.top1_mean, rsp.top5_mean, rsp.top10_mean,
                    rsp.top50_mean, rsp.median_ms, rsp.overall_mean};
            if (pending_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", got);
            end
            else
            begin
                want = pending_stats.pop_front();
                checked_results++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %h got %h", checked_results, want, got);
                end
            end
        end
    end

    // too few samples: empty, 99 held, then the first full statistics at 100
    task automatic test_sparse_window();
        send_item(MODE_QUERY, '1);
        for (int i = 0; i < 99; i++)
        begin
            send_item(MODE_RECORD, (i % 3 == 0) ? '1 : ((i % 3 == 1) ? '0 : sample_t'(i)));
        end
        send_item(MODE_QUERY, '0);
        send_item(MODE_RECORD, 16'h8001);
        send_item(MODE_QUERY, 16'h5555);
        send_item(MODE_RECORD, 16'haaaa);
        send_item(MODE_QUERY, 16'haaaa);
        wait_drained();
    endtask

    // result side held off while queries and records keep coming
    task automatic test_result_stall();
        hold_rsp = 1'b1;
        no_idle  = 1'b1;
        for (int q = 0; q < 3; q++)
        begin
            send_item(MODE_QUERY, '0);
            for (int i = 0; i < 4; i++) send_item(MODE_RECORD, pick_sample());
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // random mix, filling and then wrapping the window
    task automatic test_random_traffic();
        int burst;
        while (records_sent + queries_sent < ITEM_GOAL)
        begin
            if ($urandom_range(39) == 0)
            begin
                send_item(MODE_QUERY, sample_t'($urandom));
            end
            else
            begin
                send_item(MODE_RECORD, pick_sample());
            end
            if ($urandom_range(199) == 0)
            begin
                burst = $urandom_range(30, 10);
                no_idle = 1'b1;
                for (int i = 0; i < burst; i++) send_item(MODE_RECORD, pick_sample());
                no_idle = 1'b0;
            end
        end
        send_item(MODE_QUERY, '0);
        wait_drained();
    endtask

    // timeout
    initial
    begin
        #20000000;
        $display("sliding_window_latency_percentiles_top verification failed");
        $finish;
    end

    initial
    begin
        req.valid       <= 1'b0;
        req.mode        <= MODE_RECORD;
        req.sample_ms   <= '0;
        rst_n           = 1'b0;
        held_count      = 0;
        write_slot      = 0;
        mismatches      = 0;
        checked_results = 0;
        records_sent    = 0;
        queries_sent    = 0;
        no_idle         = 1'b0;
        hold_rsp        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sparse_window();
        test_result_stall();
        test_random_traffic();

        $display("covered %0d records and %0d queries, %0d results compared",
                 records_sent, queries_sent, checked_results);
        $display("window held %0d samples at the end, write slot %0d", held_count, write_slot);
        if (mismatches == 0 && pending_stats.size() == 0)
        begin
            $display("sliding_window_latency_percentiles_top verification clean");
        end
        else
        begin
            $display("sliding_window_latency_percentiles_top verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/swlp_pkg.sv
hdl/swlp_req_if.sv
hdl/swlp_rsp_if.sv
hdl/swlp_ram.sv
hdl/swlp_div.sv
hdl/sliding_window_latency_percentiles_top.sv
tb/sv/sliding_window_latency_percentiles_top_tb.sv
